// ===== hw/rtl/clkdr_pkg.sv =====
package clkdr_pkg;

   localparam int unsigned WORD_W          = 32;
   localparam int unsigned FIELD_W_MAX     = 16;
   localparam int unsigned CPU_TABLE_MAX   = 8;
   localparam int unsigned CPU_TABLE_SCALE = 2;

   localparam int unsigned REQ_TDATA_W = 104;
   localparam int unsigned RSP_TDATA_W = 72;

   localparam logic [1:0] CSR_DIV_MODE    = 2'd0;
   localparam logic [1:0] CSR_FIELD_SHIFT = 2'd1;
   localparam logic [1:0] CSR_FIELD_WIDTH = 2'd2;

   typedef enum logic [1:0] {
      CMD_GET   = 2'd0,
      CMD_SET   = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NODEV = 2'd1,
      ST_RANGE = 2'd2,
      ST_MODE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_POW2  = 2'd1,
      MODE_CPU   = 2'd2,
      MODE_RSVD  = 2'd3
   } mode_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] quotient;
      logic [WORD_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== hw/rtl/clkdr_div.sv =====
module clkdr_div (
   input  logic                   clock,
   input  logic                   reset,
   input  clkdr_pkg::div_req_type div_req,
   output clkdr_pkg::div_rsp_type div_rsp
);
   import clkdr_pkg::*;

   localparam int unsigned CNT_W = $clog2(WORD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] dsr_ff, dsr_in;
   logic [WORD_W:0]   trial;
   logic [WORD_W:0]   diff;

   // restoring radix-2: one quotient bit per cycle, dividend shifts out of quo_ff
   always_comb begin
      trial   = {rem_ff, quo_ff[WORD_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[WORD_W-2:0], ~diff[WORD_W]};
         rem_in = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== hw/rtl/clock_divider_rate_calc.sv =====
// Flow: IDLE takes a request, LOAD decides, DIV divides, FIN registers the response
// once the output slot is free. Only a present get with nonzero parent rate in plain
// mode or cpu mode with an in-range index, and a set that reaches the divide, use DIV.
// Throughput: one item in flight; the 32-step radix-2 divider is shared by get and set.
// Reset: synchronous, active high; clears the control word, config registers and state.
module clock_divider_rate_calc (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [0] parent_present, [32:1] src_rate, [64:33] target_rate, [96:65] word_data
   input  logic [clkdr_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [1:0] cmd
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] rate, [33:32] status, [65:34] control_word
   output logic [clkdr_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [1:0]                           csr_index,
   input  logic [4:0]                           csr_data
);
   import clkdr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LOAD = 4'b0010,
      S_DIV  = 4'b0100,
      S_FIN  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [4:0]        shift_ff, shift_in;
   logic [4:0]        width_ff, width_in;
   logic [WORD_W-1:0] word_ff, word_in;

   cmd_type           cmd_ff, cmd_in;
   logic              present_ff, present_in;
   logic [WORD_W-1:0] prate_ff, prate_in;
   logic [WORD_W-1:0] target_ff, target_in;
   logic [WORD_W-1:0] data_ff, data_in;

   status_type        status_ff, status_in;
   logic [WORD_W-1:0] rate_ff, rate_in;
   logic              use_div_ff, use_div_in;

   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [WORD_W-1:0] rsp_rate_ff, rsp_rate_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;

   logic [4:0]        eff_w;
   logic [15:0]       low_mask;
   logic [47:0]       mask_wide;
   logic [WORD_W-1:0] field_mask;
   logic [WORD_W-1:0] field_max;
   logic [WORD_W-1:0] ratio_full;
   logic [15:0]       ratio;
   logic [WORD_W-1:0] pow2_rate;

   status_type        ld_status;
   logic [WORD_W-1:0] ld_rate;
   logic              ld_div;
   logic [WORD_W-1:0] ld_divisor;

   logic [WORD_W-1:0] raw;
   logic [WORD_W-1:0] fin_rate;
   status_type        fin_status;
   logic [WORD_W-1:0] fin_word;
   logic              fire;

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   clkdr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // field placement; bits above bit 31 fall away
   always_comb begin
      eff_w      = (width_ff > 5'(FIELD_W_MAX)) ? 5'(FIELD_W_MAX) : width_ff;
      low_mask   = 16'((17'd1 << eff_w) - 17'd1);
      mask_wide  = {32'b0, low_mask} << shift_ff;
      field_mask = mask_wide[WORD_W-1:0];
      field_max  = field_mask >> shift_ff;
      ratio_full = (word_ff & field_mask) >> shift_ff;
      ratio      = ratio_full[15:0];
      pow2_rate  = (ratio >= 16'd32) ? '0 : (prate_ff >> ratio[4:0]);
   end

   // pre-divide decisions
   always_comb begin
      ld_status  = ST_OK;
      ld_rate    = '0;
      ld_div     = 1'b0;
      ld_divisor = target_ff;
      unique case (cmd_ff)
         CMD_GET: begin
            if (!present_ff) begin
               ld_status = ST_NODEV;
            end else if (prate_ff != '0) begin
               unique case (mode_ff)
                  MODE_PLAIN: begin
                     ld_div     = 1'b1;
                     ld_divisor = 32'(ratio) + 32'd1;
                  end
                  MODE_POW2: ld_rate = pow2_rate;
                  MODE_CPU: begin
                     if (ratio >= 16'd1 && ratio <= 16'(CPU_TABLE_MAX)) begin
                        ld_div     = 1'b1;
                        ld_divisor = (32'(ratio) + 32'd1) * 32'(CPU_TABLE_SCALE);
                     end
                  end
                  MODE_RSVD: ld_status = ST_MODE;
                  default: ld_status = ST_MODE;
               endcase
            end
         end
         CMD_SET: begin
            priority if (!present_ff || field_mask == '0) begin
               ld_status = ST_NODEV;
            end else if (prate_ff == '0) begin
               ld_status = (target_ff == '0) ? ST_OK : ST_RANGE;
            end else if (target_ff == '0) begin
               ld_status = ST_RANGE;
            end else if (mode_ff != MODE_PLAIN) begin
               ld_status = ST_MODE;
            end else begin
               ld_div = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign div_req.start    = (state_ff == S_LOAD) && ld_div;
   assign div_req.dividend = prate_ff;
   assign div_req.divisor  = ld_divisor;

   // ceil(p/t) - 1 from quotient and remainder
   always_comb begin
      raw        = (div_rsp.remainder != '0) ? div_rsp.quotient
                                             : div_rsp.quotient - 32'd1;
      fin_rate   = rate_ff;
      fin_status = status_ff;
      fin_word   = word_ff;
      if (use_div_ff) begin
         if (cmd_ff == CMD_GET) begin
            fin_rate = div_rsp.quotient;
         end else if (raw > field_max) begin
            fin_status = ST_RANGE;
         end else begin
            fin_word = (word_ff & ~field_mask) | ((raw << shift_ff) & field_mask);
         end
      end
      if (cmd_ff == CMD_WRITE) begin
         fin_word = data_ff;
      end
   end

   assign fire = (state_ff == S_FIN) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      shift_in      = shift_ff;
      width_in      = width_ff;
      word_in       = word_ff;
      cmd_in        = cmd_ff;
      present_in    = present_ff;
      prate_in      = prate_ff;
      target_in     = target_ff;
      data_in       = data_ff;
      status_in     = status_ff;
      rate_in       = rate_ff;
      use_div_in    = use_div_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_rate_in   = rsp_rate_ff;
      rsp_status_in = rsp_status_ff;
      rsp_word_in   = rsp_word_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_DIV_MODE:    mode_in  = mode_type'(csr_data[1:0]);
            CSR_FIELD_SHIFT: shift_in = csr_data;
            CSR_FIELD_WIDTH: width_in = csr_data;
            default: ;
         endcase
      end

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in     = cmd_type'(req_tuser);
               present_in = req_tdata[0];
               prate_in   = req_tdata[32:1];
               target_in  = req_tdata[64:33];
               data_in    = req_tdata[96:65];
               state_in   = S_LOAD;
            end
         end
         S_LOAD: begin
            status_in  = ld_status;
            rate_in    = ld_rate;
            use_div_in = ld_div;
            state_in   = ld_div ? S_DIV : S_FIN;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (fire) begin
               rsp_tvalid_in = 1'b1;
               rsp_rate_in   = fin_rate;
               rsp_status_in = fin_status;
               rsp_word_in   = fin_word;
               word_in       = fin_word;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= MODE_PLAIN;
         shift_ff      <= '0;
         width_ff      <= '0;
         word_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         shift_ff      <= shift_in;
         width_ff      <= width_in;
         word_ff       <= word_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      cmd_ff        <= cmd_in;
      present_ff    <= present_in;
      prate_ff      <= prate_in;
      target_ff     <= target_in;
      data_ff       <= data_in;
      status_ff     <= status_in;
      rate_ff       <= rate_in;
      use_div_ff    <= use_div_in;
      rsp_rate_ff   <= rsp_rate_in;
      rsp_status_ff <= rsp_status_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'b0, rsp_word_ff, rsp_status_ff, rsp_rate_ff};

   a_word_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_FIN) |=> (word_ff == $past(word_ff)))
      else $error("control word changed outside finish");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("divider finished outside divide state");

   a_set_fail_keeps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && cmd_ff == CMD_SET && fin_status != ST_OK) |->
      (fin_word == word_ff))
      else $error("failed set modified control word");

   a_mode_rate: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_status_ff == ST_MODE) |-> (rsp_rate_ff == '0))
      else $error("invalid mode returned a rate");

endmodule

// ===== tb/sv/clock_divider_rate_calc_tb.sv =====
module clock_divider_rate_calc_tb;
   import clkdr_pkg::*;

   typedef struct packed {
      logic [31:0] rate;
      status_type  status;
      logic [31:0] word;
   } rate_result_type;

   // Shadow of the divider control word and config; predicts one response per request.
   class rate_scoreboard;
      mode_type        mode;
      logic [4:0]      shift;
      logic [4:0]      width;
      logic [31:0]     word;
      rate_result_type expected_q[$];
      int              errors;

      function new();
         mode   = MODE_PLAIN;
         shift  = '0;
         width  = '0;
         word   = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [4:0] data);
         case (idx)
            CSR_DIV_MODE:    mode = mode_type'(data[1:0]);
            CSR_FIELD_SHIFT: shift = data;
            CSR_FIELD_WIDTH: width = data;
            default: ;
         endcase
      endfunction

      // widths above the maximum clamp; mask bits above bit 31 fall off
      function logic [31:0] field_mask();
         logic [63:0] m;
         int unsigned w;
         w = (width > FIELD_W_MAX) ? FIELD_W_MAX : width;
         m = ((64'd1 << w) - 64'd1) << shift;
         return m[31:0];
      endfunction

      function void calc_get(logic present, logic [31:0] prate,
                             output logic [31:0] rate, output status_type st);
         logic [31:0] ratio;
         ratio = (word & field_mask()) >> shift;
         rate  = '0;
         st    = ST_OK;
         if (!present) begin
            st = ST_NODEV;
         end else if (prate != 0) begin
            case (mode)
               MODE_POW2: rate = (ratio >= 32) ? 32'd0 : (prate >> ratio);
               MODE_CPU: begin
                  if (ratio >= 1 && ratio <= CPU_TABLE_MAX)
                     rate = prate / ((ratio + 32'd1) * CPU_TABLE_SCALE);
               end
               MODE_RSVD: st = ST_MODE;
               default: rate = prate / (ratio + 32'd1);
            endcase
         end
      endfunction

      function status_type calc_set(logic present, logic [31:0] prate, logic [31:0] target);
         logic [31:0] mask;
         logic [31:0] field_max;
         logic [63:0] ratio;
         mask      = field_mask();
         field_max = mask >> shift;
         if (!present || mask == 0) return ST_NODEV;
         if (prate == 0) return (target == 0) ? ST_OK : ST_RANGE;
         if (target == 0) return ST_RANGE;
         if (mode != MODE_PLAIN) return ST_MODE;
         // ceiling divide
         ratio = (64'(prate) + 64'(target) - 64'd1) / 64'(target);
         if (ratio - 64'd1 > 64'(field_max)) return ST_RANGE;
         word = (word & ~mask) | (((ratio[31:0] - 32'd1) << shift) & mask);
         return ST_OK;
      endfunction

      function void note_request(cmd_type cmd, logic present, logic [31:0] prate,
                                 logic [31:0] target, logic [31:0] data);
         rate_result_type r;
         logic [31:0]     rate;
         status_type      st;
         rate = '0;
         st   = ST_OK;
         case (cmd)
            CMD_GET:   calc_get(present, prate, rate, st);
            CMD_SET:   st = calc_set(present, prate, target);
            CMD_WRITE: word = data;
            default: ;
         endcase
         r.rate   = rate;
         r.status = st;
         r.word   = word;
         expected_q.push_back(r);
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("mismatch: %s", msg);
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] d);
         rate_result_type e;
         if (expected_q.size() == 0) begin
            flag($sformatf("unexpected response %h", d));
            return;
         end
         e = expected_q.pop_front();
         if (d[31:0] !== e.rate)
            flag($sformatf("rate expected %h got %h", e.rate, d[31:0]));
         if (d[33:32] !== e.status)
            flag($sformatf("status expected %0d got %0d", e.status, d[33:32]));
         if (d[65:34] !== e.word)
            flag($sformatf("control_word expected %h got %h", e.word, d[65:34]));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0]             req_tuser = CMD_GET;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [1:0]             csr_index = CSR_DIV_MODE;
   logic [4:0]             csr_data = '0;

   int send_idle_pct = 17;
   int recv_stall_pct = 79;

   rate_scoreboard sb = new();

   clock_divider_rate_calc dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: random stalls, check every accepted transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_item(cmd_type cmd, logic present, logic [31:0] prate,
                            logic [31:0] target, logic [31:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, data, target, prate, present};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(cmd, present, prate, target, data);
   endtask

   // hold off requests until every outstanding response is back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [4:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic configure(logic [4:0] mode, logic [4:0] shift, logic [4:0] width);
      wait_idle();
      write_reg(CSR_DIV_MODE, mode);
      write_reg(CSR_FIELD_SHIFT, shift);
      write_reg(CSR_FIELD_WIDTH, width);
      csr_valid <= 1'b0;
   endtask

   task automatic rand_item();
      cmd_type     cmd;
      logic        present;
      logic [31:0] prate;
      logic [31:0] target;
      logic [31:0] data;
      int unsigned pick;
      pick    = $urandom_range(99);
      cmd     = (pick < 40) ? CMD_GET : (pick < 75) ? CMD_SET :
                (pick < 90) ? CMD_WRITE : CMD_NOP;
      present = ($urandom_range(15) != 0);
      case ($urandom_range(7))
         0: prate = '0;
         1: prate = '1;
         2: prate = $urandom_range(1000);
         3, 4: prate = $urandom;
         default: prate = $urandom >> $urandom_range(31);
      endcase
      case ($urandom_range(7))
         0: target = '0;
         1: target = 32'd1;
         2: target = '1;
         3: target = $urandom;
         // near a reachable divide ratio
         default: target = prate / $urandom_range(1, 1 << $urandom_range(16))
                           + $urandom_range(1);
      endcase
      data = $urandom;
      // small field values reach the cpu table and short shifts
      if ($urandom_range(1))
         data = (data & ~(32'hFFFF << sb.shift)) | ($urandom_range(10) << sb.shift);
      send_item(cmd, present, prate, target, data);
   endtask

   initial begin
      int          issued;
      int          n;
      logic [4:0]  mode;
      logic [4:0]  shift;
      logic [4:0]  width;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no field after reset
      send_item(CMD_GET, 1'b0, 32'd1000, 32'd0, 32'd0);
      send_item(CMD_GET, 1'b1, 32'd1000, 32'd0, 32'd0);
      send_item(CMD_SET, 1'b1, 32'd1000, 32'd10, 32'd0);
      send_item(CMD_WRITE, 1'b1, 32'd0, 32'd0, 32'hFFFF_FFFF);
      send_item(CMD_NOP, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      configure(MODE_PLAIN, 5'd4, 5'd8);
      send_item(CMD_GET, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0);
      send_item(CMD_GET, 1'b1, 32'd0, 32'd0, 32'd0);
      send_item(CMD_SET, 1'b1, 32'd0, 32'd0, 32'd0);
      send_item(CMD_SET, 1'b1, 32'd0, 32'd5, 32'd0);
      send_item(CMD_SET, 1'b1, 32'd100, 32'd0, 32'd0);
      send_item(CMD_SET, 1'b1, 32'hFFFF_FFFF, 32'd1, 32'd0);
      send_item(CMD_SET, 1'b1, 32'd1000, 32'd300, 32'd0);
      send_item(CMD_GET, 1'b1, 32'd1000, 32'd0, 32'd0);
      send_item(CMD_SET, 1'b0, 32'd1000, 32'd300, 32'd0);

      configure(MODE_POW2, 5'd4, 5'd8);
      send_item(CMD_WRITE, 1'b1, 32'd0, 32'd0, 32'h0000_0210);
      send_item(CMD_GET, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0);
      send_item(CMD_SET, 1'b1, 32'd100, 32'd10, 32'd0);

      configure(MODE_CPU, 5'd4, 5'd8);
      send_item(CMD_WRITE, 1'b1, 32'd0, 32'd0, 32'h0000_0080);
      send_item(CMD_GET, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0);
      send_item(CMD_WRITE, 1'b1, 32'd0, 32'd0, 32'h0000_0090);
      send_item(CMD_GET, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0);

      configure(MODE_RSVD, 5'd4, 5'd8);
      send_item(CMD_GET, 1'b1, 32'd1000, 32'd0, 32'd0);
      send_item(CMD_SET, 1'b1, 32'd1000, 32'd10, 32'd0);

      // oversized width clamps; only bit 31 survives the mask
      configure(MODE_PLAIN, 5'd31, 5'd31);
      send_item(CMD_SET, 1'b1, 32'd3, 32'd1, 32'd0);
      send_item(CMD_SET, 1'b1, 32'd2, 32'd1, 32'd0);
      send_item(CMD_GET, 1'b1, 32'd100, 32'd0, 32'd0);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 17;
               recv_stall_pct = 79;
            end
            1: begin
               send_idle_pct  = 79;
               recv_stall_pct = 17;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         issued = 0;
         while (issued < 120) begin
            mode = ($urandom_range(9) < 5) ? 5'(MODE_PLAIN) : 5'($urandom_range(3));
            case ($urandom_range(3))
               0: shift = 5'd0;
               1: shift = 5'd31;
               default: shift = 5'($urandom_range(16));
            endcase
            case ($urandom_range(5))
               0: width = 5'd0;
               1: width = 5'd16;
               2: width = 5'(17 + $urandom_range(14));
               default: width = 5'($urandom_range(1, 16));
            endcase
            configure(mode, shift, width);
            n = $urandom_range(15, 40);
            repeat (n) rand_item();
            issued += n;
         end
      end

      wait_idle();
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("clock_divider_rate_calc_tb: clean");
      end else begin
         $display("clock_divider_rate_calc_tb: errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("clock_divider_rate_calc_tb: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/clkdr_pkg.sv
hw/rtl/clkdr_div.sv
hw/rtl/clock_divider_rate_calc.sv
tb/sv/clock_divider_rate_calc_tb.sv
